### hdl/lavm_pkg.sv
package lavm_pkg;

   localparam logic [63:0] LEN2_FLOOR = 64'd42950;
   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS = 17;

   localparam logic [2:0] CSR_TARGET_X = 3'd0;
   localparam logic [2:0] CSR_TARGET_Y = 3'd1;
   localparam logic [2:0] CSR_TARGET_Z = 3'd2;
   localparam logic [2:0] CSR_UP_X = 3'd3;
   localparam logic [2:0] CSR_UP_Y = 3'd4;
   localparam logic [2:0] CSR_UP_Z = 3'd5;

   localparam logic signed [31:0] UP_Y_RESET = 32'sh0001_0000;

   localparam logic signed [51:0] SAT_MAX = 52'sh0_0000_7FFF_FFFF;
   localparam logic signed [51:0] SAT_MIN = -52'sh0_0000_8000_0000;

   typedef logic signed [31:0] comp_type;

   typedef struct packed {
      comp_type x;
      comp_type y;
      comp_type z;
   } vec3_type;

   typedef struct packed {
      comp_type eye_x;
      comp_type eye_y;
      comp_type eye_z;
   } req_type;

   typedef struct packed {
      comp_type side_x;
      comp_type side_y;
      comp_type side_z;
      comp_type true_up_x;
      comp_type true_up_y;
      comp_type true_up_z;
      comp_type forward_x;
      comp_type forward_y;
      comp_type forward_z;
      comp_type offset_side;
      comp_type offset_up;
      comp_type offset_forward;
   } rsp_type;

   function automatic logic signed [63:0] mul_ss(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
      return 64'(a) * 64'(b);
   endfunction

   // q32.32 product to q16.16, nearest, ties away from zero
   function automatic logic signed [47:0] rnd_q(input logic signed [63:0] p);
      logic [63:0] m;
      logic [63:0] r;
      m = p[63] ? 64'(-p) : 64'(p);
      r = (m + 64'h8000) >> 16;
      return p[63] ? -$signed(r[47:0]) : $signed(r[47:0]);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
      if (v > SAT_MAX) begin
         return 32'sh7FFF_FFFF;
      end else if (v < SAT_MIN) begin
         return -32'sh8000_0000;
      end
      return 32'(v);
   endfunction

   function automatic logic signed [31:0] cross_term(input logic signed [63:0] pa,
                                                     input logic signed [63:0] pb);
      return sat32(52'(rnd_q(pa)) - 52'(rnd_q(pb)));
   endfunction

   function automatic logic signed [31:0] dot_term(input logic signed [63:0] p0,
                                                   input logic signed [63:0] p1,
                                                   input logic signed [63:0] p2,
                                                   input logic neg);
      logic signed [51:0] s;
      s = 52'(rnd_q(p0)) + 52'(rnd_q(p1)) + 52'(rnd_q(p2));
      return sat32(neg ? -s : s);
   endfunction

endpackage

### hdl/look_at_view_matrix_unit.sv
// throughput: one item per cycle while no result is stalled; each normalize
// uses a 32-stage square root and a 17-stage divider, which set the depth
// a stalled result freezes every stage, empty ones included
// reset (synchronous): pipeline emptied, target = (0, 0, 0), up = (0, 1.0, 0)
module look_at_view_matrix_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lavm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lavm_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_wdata
);

   localparam int VEC_W = $bits(lavm_pkg::vec3_type);

   logic signed [31:0] tgt_x_ff, tgt_y_ff, tgt_z_ff;
   logic signed [31:0] up_x_ff, up_y_ff, up_z_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tgt_x_ff <= 32'sd0;
         tgt_y_ff <= 32'sd0;
         tgt_z_ff <= 32'sd0;
         up_x_ff <= 32'sd0;
         up_y_ff <= lavm_pkg::UP_Y_RESET;
         up_z_ff <= 32'sd0;
      end else if (csr_valid) begin
         unique case (csr_index)
            lavm_pkg::CSR_TARGET_X: tgt_x_ff <= $signed(csr_wdata);
            lavm_pkg::CSR_TARGET_Y: tgt_y_ff <= $signed(csr_wdata);
            lavm_pkg::CSR_TARGET_Z: tgt_z_ff <= $signed(csr_wdata);
            lavm_pkg::CSR_UP_X: up_x_ff <= $signed(csr_wdata);
            lavm_pkg::CSR_UP_Y: up_y_ff <= $signed(csr_wdata);
            lavm_pkg::CSR_UP_Z: up_z_ff <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   logic en;
   logic rsp_valid_ff;

   assign en = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   // target minus eye
   lavm_pkg::vec3_type d_ff, eye1_ff;
   logic               v1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff.x <= lavm_pkg::sat32(52'(tgt_x_ff) - 52'($signed(req_data.eye_x)));
         d_ff.y <= lavm_pkg::sat32(52'(tgt_y_ff) - 52'($signed(req_data.eye_y)));
         d_ff.z <= lavm_pkg::sat32(52'(tgt_z_ff) - 52'($signed(req_data.eye_z)));
         eye1_ff.x <= req_data.eye_x;
         eye1_ff.y <= req_data.eye_y;
         eye1_ff.z <= req_data.eye_z;
      end
   end

   // forward
   logic               vn1;
   lavm_pkg::vec3_type fwd_n1;
   logic [VEC_W-1:0]   eye_n1;

   lavm_norm #(.CARRY_W(VEC_W)) u_norm_fwd (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v1_ff),
      .in_vec    (d_ff),
      .in_carry  (eye1_ff),
      .out_valid (vn1),
      .out_vec   (fwd_n1),
      .out_carry (eye_n1)
   );

   // up x forward
   logic signed [63:0] pa_ff [6];
   lavm_pkg::vec3_type fwd2_ff, eye2_ff;
   logic               v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= vn1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pa_ff[0] <= lavm_pkg::mul_ss(up_y_ff, fwd_n1.z);
         pa_ff[1] <= lavm_pkg::mul_ss(up_z_ff, fwd_n1.y);
         pa_ff[2] <= lavm_pkg::mul_ss(up_z_ff, fwd_n1.x);
         pa_ff[3] <= lavm_pkg::mul_ss(up_x_ff, fwd_n1.z);
         pa_ff[4] <= lavm_pkg::mul_ss(up_x_ff, fwd_n1.y);
         pa_ff[5] <= lavm_pkg::mul_ss(up_y_ff, fwd_n1.x);
         fwd2_ff <= fwd_n1;
         eye2_ff <= lavm_pkg::vec3_type'(eye_n1);
      end
   end

   lavm_pkg::vec3_type sv3_ff, fwd3_ff, eye3_ff;
   logic               v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sv3_ff.x <= lavm_pkg::cross_term(pa_ff[0], pa_ff[1]);
         sv3_ff.y <= lavm_pkg::cross_term(pa_ff[2], pa_ff[3]);
         sv3_ff.z <= lavm_pkg::cross_term(pa_ff[4], pa_ff[5]);
         fwd3_ff <= fwd2_ff;
         eye3_ff <= eye2_ff;
      end
   end

   // side
   logic                 vn2;
   lavm_pkg::vec3_type   side_n2;
   logic [2*VEC_W-1:0]   carry_n2;

   lavm_norm #(.CARRY_W(2 * VEC_W)) u_norm_side (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v3_ff),
      .in_vec    (sv3_ff),
      .in_carry  ({eye3_ff, fwd3_ff}),
      .out_valid (vn2),
      .out_vec   (side_n2),
      .out_carry (carry_n2)
   );

   lavm_pkg::vec3_type fwd_n2;

   assign fwd_n2 = lavm_pkg::vec3_type'(carry_n2[VEC_W-1:0]);

   // forward x side
   logic signed [63:0] pb_ff [6];
   lavm_pkg::vec3_type side4_ff, fwd4_ff, eye4_ff;
   logic               v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= vn2;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pb_ff[0] <= lavm_pkg::mul_ss(fwd_n2.y, side_n2.z);
         pb_ff[1] <= lavm_pkg::mul_ss(fwd_n2.z, side_n2.y);
         pb_ff[2] <= lavm_pkg::mul_ss(fwd_n2.z, side_n2.x);
         pb_ff[3] <= lavm_pkg::mul_ss(fwd_n2.x, side_n2.z);
         pb_ff[4] <= lavm_pkg::mul_ss(fwd_n2.x, side_n2.y);
         pb_ff[5] <= lavm_pkg::mul_ss(fwd_n2.y, side_n2.x);
         side4_ff <= side_n2;
         fwd4_ff <= fwd_n2;
         eye4_ff <= lavm_pkg::vec3_type'(carry_n2[2*VEC_W-1:VEC_W]);
      end
   end

   lavm_pkg::vec3_type up5_ff, side5_ff, fwd5_ff, eye5_ff;
   logic               v5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         up5_ff.x <= lavm_pkg::cross_term(pb_ff[0], pb_ff[1]);
         up5_ff.y <= lavm_pkg::cross_term(pb_ff[2], pb_ff[3]);
         up5_ff.z <= lavm_pkg::cross_term(pb_ff[4], pb_ff[5]);
         side5_ff <= side4_ff;
         fwd5_ff <= fwd4_ff;
         eye5_ff <= eye4_ff;
      end
   end

   // translation products
   logic signed [63:0] pc_ff [9];
   lavm_pkg::vec3_type up6_ff, side6_ff, fwd6_ff;
   logic               v6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (en) begin
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pc_ff[0] <= lavm_pkg::mul_ss(side5_ff.x, eye5_ff.x);
         pc_ff[1] <= lavm_pkg::mul_ss(side5_ff.y, eye5_ff.y);
         pc_ff[2] <= lavm_pkg::mul_ss(side5_ff.z, eye5_ff.z);
         pc_ff[3] <= lavm_pkg::mul_ss(up5_ff.x, eye5_ff.x);
         pc_ff[4] <= lavm_pkg::mul_ss(up5_ff.y, eye5_ff.y);
         pc_ff[5] <= lavm_pkg::mul_ss(up5_ff.z, eye5_ff.z);
         pc_ff[6] <= lavm_pkg::mul_ss(fwd5_ff.x, eye5_ff.x);
         pc_ff[7] <= lavm_pkg::mul_ss(fwd5_ff.y, eye5_ff.y);
         pc_ff[8] <= lavm_pkg::mul_ss(fwd5_ff.z, eye5_ff.z);
         up6_ff <= up5_ff;
         side6_ff <= side5_ff;
         fwd6_ff <= fwd5_ff;
      end
   end

   // output register
   lavm_pkg::rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff.side_x <= side6_ff.x;
         rsp_data_ff.side_y <= side6_ff.y;
         rsp_data_ff.side_z <= side6_ff.z;
         rsp_data_ff.true_up_x <= up6_ff.x;
         rsp_data_ff.true_up_y <= up6_ff.y;
         rsp_data_ff.true_up_z <= up6_ff.z;
         rsp_data_ff.forward_x <= fwd6_ff.x;
         rsp_data_ff.forward_y <= fwd6_ff.y;
         rsp_data_ff.forward_z <= fwd6_ff.z;
         rsp_data_ff.offset_side <= lavm_pkg::dot_term(pc_ff[0], pc_ff[1], pc_ff[2], 1'b1);
         rsp_data_ff.offset_up <= lavm_pkg::dot_term(pc_ff[3], pc_ff[4], pc_ff[5], 1'b1);
         rsp_data_ff.offset_forward <= lavm_pkg::dot_term(pc_ff[6], pc_ff[7], pc_ff[8], 1'b0);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

### hdl/lavm_norm.sv
module lavm_norm #(
   parameter int CARRY_W = 96
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  lavm_pkg::vec3_type  in_vec,
   input  logic [CARRY_W-1:0]  in_carry,
   output logic                out_valid,
   output lavm_pkg::vec3_type  out_vec,
   output logic [CARRY_W-1:0]  out_carry
);

   localparam int SQ = lavm_pkg::SQRT_STEPS;
   localparam int DV = lavm_pkg::DIV_STEPS;

   logic signed [31:0] in_c [3];

   assign in_c[0] = $signed(in_vec.x);
   assign in_c[1] = $signed(in_vec.y);
   assign in_c[2] = $signed(in_vec.z);

   // squares
   logic [62:0]        sq_ff [3];
   logic signed [31:0] vec_a_ff [3];
   logic [CARRY_W-1:0] carry_a_ff;
   logic               valid_a_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else if (en) begin
         valid_a_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= 63'(lavm_pkg::mul_ss(in_c[i], in_c[i]));
            vec_a_ff[i] <= in_c[i];
         end
         carry_a_ff <= in_carry;
      end
   end

   // square root, one result bit per stage
   logic [63:0]        rem_ff [SQ+1];
   logic [63:0]        root_ff [SQ+1];
   logic               short_s_ff [SQ+1];
   logic signed [31:0] vec_s_ff [SQ+1][3];
   logic [CARRY_W-1:0] carry_s_ff [SQ+1];
   logic               valid_s_ff [SQ+1];
   logic [63:0]        len2_in;

   assign len2_in = {1'b0, sq_ff[0]} + {1'b0, sq_ff[1]} + {1'b0, sq_ff[2]};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_s_ff[0] <= 1'b0;
      end else if (en) begin
         valid_s_ff[0] <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= len2_in;
         root_ff[0] <= 64'd0;
         short_s_ff[0] <= (len2_in < lavm_pkg::LEN2_FLOOR);
         vec_s_ff[0] <= vec_a_ff;
         carry_s_ff[0] <= carry_a_ff;
      end
   end

   for (genvar k = 0; k < SQ; k++) begin : g_sqrt
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
      logic [63:0] trial;

      assign trial = root_ff[k] + BIT;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_s_ff[k+1] <= 1'b0;
         end else if (en) begin
            valid_s_ff[k+1] <= valid_s_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            if (rem_ff[k] >= trial) begin
               rem_ff[k+1] <= rem_ff[k] - trial;
               root_ff[k+1] <= (root_ff[k] >> 1) + BIT;
            end else begin
               rem_ff[k+1] <= rem_ff[k];
               root_ff[k+1] <= root_ff[k] >> 1;
            end
            short_s_ff[k+1] <= short_s_ff[k];
            vec_s_ff[k+1] <= vec_s_ff[k];
            carry_s_ff[k+1] <= carry_s_ff[k];
         end
      end
   end

   // restoring division of rounded numerator by the length
   logic [48:0]        drem_ff [DV+1][3];
   logic [16:0]        quo_ff [DV+1][3];
   logic [31:0]        len_ff [DV+1];
   logic               short_d_ff [DV+1];
   logic signed [31:0] vec_d_ff [DV+1][3];
   logic [CARRY_W-1:0] carry_d_ff [DV+1];
   logic               valid_d_ff [DV+1];
   logic [31:0]        len_in;
   logic [31:0]        mag_in [3];

   assign len_in = root_ff[SQ][31:0];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag_in[i] = vec_s_ff[SQ][i][31] ? 32'(-vec_s_ff[SQ][i]) : 32'(vec_s_ff[SQ][i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_d_ff[0] <= 1'b0;
      end else if (en) begin
         valid_d_ff[0] <= valid_s_ff[SQ];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            drem_ff[0][i] <= {1'b0, mag_in[i], 16'd0} + 49'(len_in >> 1);
            quo_ff[0][i] <= 17'd0;
         end
         len_ff[0] <= len_in;
         short_d_ff[0] <= short_s_ff[SQ];
         vec_d_ff[0] <= vec_s_ff[SQ];
         carry_d_ff[0] <= carry_s_ff[SQ];
      end
   end

   for (genvar t = 0; t < DV; t++) begin : g_div
      localparam int J = DV - 1 - t;
      logic [48:0] test;

      assign test = 49'(len_ff[t]) << J;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_d_ff[t+1] <= 1'b0;
         end else if (en) begin
            valid_d_ff[t+1] <= valid_d_ff[t];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            for (int i = 0; i < 3; i++) begin
               if (drem_ff[t][i] >= test) begin
                  drem_ff[t+1][i] <= drem_ff[t][i] - test;
                  quo_ff[t+1][i] <= quo_ff[t][i] | (17'd1 << J);
               end else begin
                  drem_ff[t+1][i] <= drem_ff[t][i];
                  quo_ff[t+1][i] <= quo_ff[t][i];
               end
            end
            len_ff[t+1] <= len_ff[t];
            short_d_ff[t+1] <= short_d_ff[t];
            vec_d_ff[t+1] <= vec_d_ff[t];
            carry_d_ff[t+1] <= carry_d_ff[t];
         end
      end
   end

   // sign restore, short vectors pass unchanged
   logic signed [31:0] res_in [3];
   lavm_pkg::vec3_type out_vec_ff;
   logic [CARRY_W-1:0] out_carry_ff;
   logic               out_valid_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (short_d_ff[DV]) begin
            res_in[i] = vec_d_ff[DV][i];
         end else if (vec_d_ff[DV][i][31]) begin
            res_in[i] = 32'sd0 - $signed({15'd0, quo_ff[DV][i]});
         end else begin
            res_in[i] = $signed({15'd0, quo_ff[DV][i]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= valid_d_ff[DV];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_vec_ff.x <= res_in[0];
         out_vec_ff.y <= res_in[1];
         out_vec_ff.z <= res_in[2];
         out_carry_ff <= carry_d_ff[DV];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_vec = out_vec_ff;
   assign out_carry = out_carry_ff;

endmodule
